// ===== src/array_list_engine_defines.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Check prop at every clock edge outside reset.
`define ALE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop at every clock edge, reset included.
`define ALE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALE_ASSERT(label, prop, msg)
`define ALE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== src/ale_pkg.sv =====
// Types and constants shared by the list engine and its storage cells.
package ale_pkg;

  localparam int unsigned KIND_W       = 4;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STAT_W       = 3;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned DEF_CAPACITY = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK    = 4'd0,
    KIND_POP_BACK     = 4'd1,
    KIND_PUSH_FRONT   = 4'd2,
    KIND_POP_FRONT    = 4'd3,
    KIND_INSERT       = 4'd4,
    KIND_ERASE        = 4'd5,
    KIND_FIND         = 4'd6,
    KIND_REMOVE_FIRST = 4'd7,
    KIND_REMOVE_ALL   = 4'd8,
    KIND_FRONT        = 4'd9,
    KIND_BACK         = 4'd10
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BADPOS    = 3'd3,
    STAT_NOTFOUND  = 3'd4
  } status_t;

  // Broadcast command to the cell row.
  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_OPEN  = 2'd1,
    MODE_CLOSE = 2'd2
  } cell_mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_DONE = 2'd2
  } state_t;

endpackage

// ===== src/ale_cell.sv =====
// One storage cell of the list row: holds an entry and trades with its neighbors.
module ale_cell import ale_pkg::*; #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  cell_mode_t               mode,
  input  logic [IW-1:0]            lo,
  input  logic [IW-1:0]            hi,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     match
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // Open: load at lo, take left neighbor above lo up to hi.
  // Close: take right neighbor from lo up to just below hi.
  always_ff @(posedge clk) begin
    case (mode)
      MODE_OPEN: begin
        if (MY_IDX == lo) begin
          data <= value;
        end else if (MY_IDX > lo && MY_IDX <= hi) begin
          data <= left_data;
        end
      end
      MODE_CLOSE: begin
        if (MY_IDX >= lo && MY_IDX < hi) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign match = (data == value);

endmodule

// ===== src/array_list_engine.sv =====
// Top level of the fixed-capacity ordered list engine.
//
//  channel | signals                          | role
//  --------+----------------------------------+--------------------------------
//  op      | op_valid op_stall kind position  | one list operation per beat
//          | value                            |
//  res     | res_valid res_stall status found | one result beat per operation
//          | read_value count                 |
//
//  One operation at a time. Push, pop, insert, erase, front and back need
//  no scan and finish in RUN; where they move entries, the whole row of
//  cells shifts at once. Find, remove first and remove all walk a cursor
//  over the entries, one entry per cycle, until a match ends the scan or
//  the cursor passes the last entry (remove all either advances the cursor
//  or drops an entry each cycle). The result beat is offered the cycle after
//  RUN ends; the next op beat is taken once the result beat has been taken.
//  Reset clears the count and the controller; entries are not cleared.
//  A stalled result holds all result fields; op_stall stays high meanwhile.
module array_list_engine import ale_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      op_valid,
  output logic                      op_stall,
  input  logic [KIND_W-1:0]         kind,
  input  logic [POS_W-1:0]          position,
  input  logic signed [DATA_W-1:0]  value,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [STAT_W-1:0]         status,
  output logic                      found,
  output logic signed [DATA_W-1:0]  read_value,
  output logic [COUNT_W-1:0]        count
);

  `include "array_list_engine_defines.svh"

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  // Controller and operation registers
  state_t                    state, state_next;
  logic [KIND_W-1:0]         kind_r;
  logic [POS_W-1:0]          pos_r;
  logic signed [DATA_W-1:0]  value_r;
  logic [CW-1:0]             count_r, count_next;
  logic [CW-1:0]             cursor, cursor_next;
  status_t                   status_r, status_next;
  logic                      found_r, found_next;
  logic signed [DATA_W-1:0]  read_r, read_next;

  // Cell row
  cell_mode_t                mode;
  logic [IW-1:0]             lo, hi;
  logic signed [DATA_W-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0]       match;

  logic                      accept;
  logic                      done;
  logic                      is_full, is_empty;
  logic [CW-1:0]             cnt_m1;
  logic [CW+POS_W-1:0]       pos_x, cnt_x;
  logic                      bad_pos;
  logic                      in_list;
  logic                      hit;
  logic [IW-1:0]             rd_idx;
  logic [CW+COUNT_W-1:0]     cnt_wide;

  assign accept   = op_valid && !op_stall;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);
  assign cnt_m1   = count_r - 1'b1;
  assign pos_x    = (CW+POS_W)'(pos_r);
  assign cnt_x    = (CW+POS_W)'(count_r);
  assign bad_pos  = (pos_x >= cnt_x);
  assign in_list  = (cursor < count_r);
  assign hit      = in_list && match[cursor[IW-1:0]];
  assign rd_idx   = (kind_r == KIND_FRONT) ? '0 : cnt_m1[IW-1:0];

  // Row of cells: each hands its entry to a neighbor on open or close.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = value_r;
    end else begin : g_left
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = value_r;
    end else begin : g_right
      assign right_in = cell_data[g+1];
    end
    ale_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .mode       (mode),
      .lo         (lo),
      .hi         (hi),
      .value      (value_r),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g]),
      .match      (match[g])
    );
  end

  // Work done in RUN: row command, count update and result.
  always_comb begin
    mode        = MODE_HOLD;
    lo          = '0;
    hi          = '0;
    count_next  = count_r;
    cursor_next = cursor;
    status_next = STAT_OK;
    found_next  = found_r;
    read_next   = '0;
    done        = 1'b1;
    unique case (kind_r) inside
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end else begin
          mode       = MODE_OPEN;
          lo         = (kind_r == KIND_PUSH_BACK) ? count_r[IW-1:0] : '0;
          hi         = count_r[IW-1:0];
          count_next = count_r + 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          status_next = STAT_EMPTY;
        end else begin
          count_next = cnt_m1;
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          status_next = STAT_EMPTY;
        end else begin
          mode       = MODE_CLOSE;
          lo         = '0;
          hi         = cnt_m1[IW-1:0];
          count_next = cnt_m1;
        end
      end
      KIND_INSERT: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end else if (bad_pos) begin
          status_next = STAT_BADPOS;
        end else begin
          mode       = MODE_OPEN;
          lo         = IW'(pos_r);
          hi         = count_r[IW-1:0];
          count_next = count_r + 1'b1;
        end
      end
      KIND_ERASE: begin
        if (is_empty) begin
          status_next = STAT_EMPTY;
        end else if (bad_pos) begin
          status_next = STAT_BADPOS;
        end else begin
          mode       = MODE_CLOSE;
          lo         = IW'(pos_r);
          hi         = cnt_m1[IW-1:0];
          count_next = cnt_m1;
        end
      end
      KIND_FIND, KIND_REMOVE_FIRST, KIND_REMOVE_ALL: begin
        if (!in_list) begin
          // Cursor ran past the last entry: close out the scan.
          status_next = found_r ? STAT_OK : STAT_NOTFOUND;
        end else if (hit) begin
          found_next = 1'b1;
          if (kind_r != KIND_FIND) begin
            // Drop the matching entry; the cursor stays on the slot.
            mode       = MODE_CLOSE;
            lo         = cursor[IW-1:0];
            hi         = cnt_m1[IW-1:0];
            count_next = cnt_m1;
          end
          done = (kind_r != KIND_REMOVE_ALL);
        end else begin
          cursor_next = cursor + 1'b1;
          done        = 1'b0;
        end
      end
      KIND_FRONT, KIND_BACK: begin
        if (is_empty) begin
          status_next = STAT_EMPTY;
        end else begin
          read_next = cell_data[rd_idx];
        end
      end
      default: begin
      end
    endcase
    if (state != S_RUN) begin
      mode = MODE_HOLD;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (op_valid) state_next = S_RUN;
      S_RUN:  if (done) state_next = S_DONE;
      S_DONE: if (!res_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    op_stall  = 1'b1;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE: op_stall = 1'b0;
      S_RUN:  op_stall = 1'b1;
      S_DONE: res_valid = 1'b1;
      default: op_stall = 1'b1;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count_r <= '0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        count_r <= count_next;
      end
    end
  end

  // Operation and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind;
      pos_r   <= position;
      value_r <= value;
      cursor  <= '0;
      found_r <= 1'b0;
    end else if (state == S_RUN) begin
      cursor   <= cursor_next;
      found_r  <= found_next;
      status_r <= status_next;
      read_r   <= read_next;
    end
  end

  assign cnt_wide   = (CW+COUNT_W)'(count_r);
  assign count      = cnt_wide[COUNT_W-1:0];
  assign status     = status_r;
  assign found      = found_r;
  assign read_value = read_r;

  `ALE_ASSERT(a_count_cap, count_r <= FULL_CNT, "entry count beyond capacity")
  `ALE_ASSERT(a_cursor_bound, state == S_RUN |-> cursor <= count_r, "scan cursor past count")
  `ALE_ASSERT(a_accept_runs, accept |=> state == S_RUN, "accepted beat did not start work")
  `ALE_ASSERT(a_result_holds, res_valid && res_stall |=> res_valid && $stable(count_r), "beat moved")
  `ALE_ASSERT(a_no_overlap, res_valid |-> op_stall, "op taken while a result is pending")
  `ALE_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE && count_r == '0, "reset not idle")

endmodule

// ===== test/tb_array_list_engine.sv =====
// Self-checking testbench for the fixed-capacity ordered list engine.
`timescale 1ns / 100ps

module tb_array_list_engine import ale_pkg::*; ();

  localparam int unsigned CAPACITY    = DEF_CAPACITY;
  localparam int          RANDOM_OPS  = 950;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          REPORT_MAX  = 10;

  // Kinds outside the enum; the engine must treat them as no-ops.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd11;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;

  // One result beat as the engine reports it.
  typedef struct packed {
    status_t                   status;
    logic                      found;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          pos;
    logic signed [DATA_W-1:0]  value;
    bit                        typed;
    list_result_t              want;
  } op_row_t;

  // Bias of the random stream, switched every few dozen beats so the list
  // swings between empty and full.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} op_mix_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      op_valid = 1'b0;
  logic                      op_stall;
  logic [KIND_W-1:0]         op_kind = '0;
  logic [POS_W-1:0]          op_pos = '0;
  logic signed [DATA_W-1:0]  op_value = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic [STAT_W-1:0]         res_status;
  logic                      res_found;
  logic signed [DATA_W-1:0]  res_read_value;
  logic [COUNT_W-1:0]        res_count;

  // Suppress all idling on both sides while set.
  logic                      steady = 1'b0;

  // Shadow copy of the list, advanced once per accepted op beat.
  logic signed [DATA_W-1:0]  model_words [CAPACITY];
  int                        model_len = 0;

  list_result_t              pending_results [$];
  int                        mismatches = 0;

  logic signed [DATA_W-1:0]  value_pool [8] = '{
    32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
    32'sd1, 32'sd42, -32'sd42, 32'sh5a5a5a5a
  };
  logic [KIND_W-1:0]         grow_kinds [3] = '{KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT};
  logic [KIND_W-1:0]         shrink_kinds [5] = '{
    KIND_POP_BACK, KIND_POP_FRONT, KIND_ERASE, KIND_REMOVE_FIRST, KIND_REMOVE_ALL
  };

  // Directed opening: every empty-list refusal, both value extremes, reads of
  // front and back, positions past the count, the spare kinds, and matching
  // removals over duplicates.
  op_row_t directed_ops [24] = '{
    '{KIND_FRONT,        4'd0,  32'sd0,         1'b1, '{STAT_EMPTY,    1'b0, 32'sd0, 5'd0}},
    '{KIND_BACK,         4'd0,  32'sd0,         1'b1, '{STAT_EMPTY,    1'b0, 32'sd0, 5'd0}},
    '{KIND_POP_BACK,     4'd0,  32'sd0,         1'b1, '{STAT_EMPTY,    1'b0, 32'sd0, 5'd0}},
    '{KIND_POP_FRONT,    4'd0,  32'sd0,         1'b1, '{STAT_EMPTY,    1'b0, 32'sd0, 5'd0}},
    '{KIND_ERASE,        4'd0,  32'sd0,         1'b1, '{STAT_EMPTY,    1'b0, 32'sd0, 5'd0}},
    '{KIND_INSERT,       4'd0,  32'sd5,         1'b1, '{STAT_BADPOS,   1'b0, 32'sd0, 5'd0}},
    '{KIND_FIND,         4'd0,  32'sd5,         1'b1, '{STAT_NOTFOUND, 1'b0, 32'sd0, 5'd0}},
    '{KIND_REMOVE_FIRST, 4'd0,  32'sd5,         1'b1, '{STAT_NOTFOUND, 1'b0, 32'sd0, 5'd0}},
    '{KIND_REMOVE_ALL,   4'd0,  32'sd5,         1'b1, '{STAT_NOTFOUND, 1'b0, 32'sd0, 5'd0}},
    '{KIND_PUSH_BACK,    4'd0,  32'sh7fffffff,  1'b1, '{STAT_OK,       1'b0, 32'sd0, 5'd1}},
    '{KIND_PUSH_FRONT,   4'd0,  32'sh80000000,  1'b1, '{STAT_OK,       1'b0, 32'sd0, 5'd2}},
    '{KIND_FRONT,        4'd0,  32'sd0,         1'b1,
      '{STAT_OK, 1'b0, 32'sh80000000, 5'd2}},
    '{KIND_BACK,         4'd0,  32'sd0,         1'b1,
      '{STAT_OK, 1'b0, 32'sh7fffffff, 5'd2}},
    '{KIND_INSERT,       4'd1,  -32'sd1,        1'b0, '0},
    '{KIND_INSERT,       4'd15, 32'sd9,         1'b1, '{STAT_BADPOS,   1'b0, 32'sd0, 5'd3}},
    '{KIND_ERASE,        4'd3,  32'sd0,         1'b1, '{STAT_BADPOS,   1'b0, 32'sd0, 5'd3}},
    '{KIND_SPARE_LO,     4'd0,  32'sd0,         1'b1, '{STAT_OK,       1'b0, 32'sd0, 5'd3}},
    '{KIND_SPARE_HI,     4'd15, -32'sd1,        1'b1, '{STAT_OK,       1'b0, 32'sd0, 5'd3}},
    '{KIND_PUSH_BACK,    4'd0,  -32'sd1,        1'b0, '0},
    '{KIND_FIND,         4'd0,  -32'sd1,        1'b0, '0},
    '{KIND_REMOVE_ALL,   4'd0,  -32'sd1,        1'b0, '0},
    '{KIND_REMOVE_FIRST, 4'd0,  32'sh7fffffff,  1'b0, '0},
    '{KIND_ERASE,        4'd0,  32'sd0,         1'b0, '0},
    '{KIND_BACK,         4'd0,  32'sd0,         1'b1, '{STAT_EMPTY,    1'b0, 32'sd0, 5'd0}}
  };

  array_list_engine #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .kind      (op_kind),
    .position  (op_pos),
    .value     (op_value),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (res_status),
    .found     (res_found),
    .read_value(res_read_value),
    .count     (res_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one list operation to the shadow list and return the result the
  // engine owes for it. Inserts open a gap and shift later words up; removals
  // close a gap and shift later words down.
  function automatic list_result_t apply_list_op(logic [KIND_W-1:0] k, logic [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] v);
    list_result_t r;
    int           open_at;
    int           close_at;
    int           keep;
    r        = '{STAT_OK, 1'b0, '0, '0};
    open_at  = -1;
    close_at = -1;
    case (k)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (model_len >= CAPACITY) r.status = STAT_FULL;
        else open_at = (k == KIND_PUSH_BACK) ? model_len : 0;
      end
      KIND_POP_BACK: begin
        if (model_len == 0) r.status = STAT_EMPTY;
        else model_len--;
      end
      KIND_POP_FRONT: begin
        if (model_len == 0) r.status = STAT_EMPTY;
        else close_at = 0;
      end
      KIND_INSERT: begin
        // Position must name an existing entry, so an empty list refuses.
        if (model_len >= CAPACITY) r.status = STAT_FULL;
        else if (int'(pos) >= model_len) r.status = STAT_BADPOS;
        else open_at = int'(pos);
      end
      KIND_ERASE: begin
        if (model_len == 0) r.status = STAT_EMPTY;
        else if (int'(pos) >= model_len) r.status = STAT_BADPOS;
        else close_at = int'(pos);
      end
      KIND_FIND, KIND_REMOVE_FIRST: begin
        r.status = STAT_NOTFOUND;
        for (int i = 0; i < model_len && !r.found; i++) begin
          if (model_words[i] == v) begin
            r.status = STAT_OK;
            r.found  = 1'b1;
            if (k == KIND_REMOVE_FIRST) close_at = i;
          end
        end
      end
      KIND_REMOVE_ALL: begin
        // Compact survivors in order, drop every match.
        keep = 0;
        for (int i = 0; i < model_len; i++) begin
          if (model_words[i] == v) begin
            r.found = 1'b1;
          end else begin
            model_words[keep] = model_words[i];
            keep++;
          end
        end
        model_len = keep;
        r.status  = r.found ? STAT_OK : STAT_NOTFOUND;
      end
      KIND_FRONT, KIND_BACK: begin
        if (model_len == 0) r.status = STAT_EMPTY;
        else r.read_value = model_words[(k == KIND_FRONT) ? 0 : model_len - 1];
      end
      default: ;
    endcase
    if (open_at >= 0) begin
      for (int i = model_len; i > open_at; i--) model_words[i] = model_words[i - 1];
      model_words[open_at] = v;
      model_len++;
    end
    if (close_at >= 0) begin
      for (int i = close_at + 1; i < model_len; i++) model_words[i - 1] = model_words[i];
      model_len--;
    end
    r.count = COUNT_W'(model_len);
    return r;
  endfunction

  // Offer one op beat, hold it until taken, then log what the engine owes.
  // Called at a rising edge; returns at the edge that accepted the beat.
  task automatic send_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] v, input bit typed,
                         input list_result_t want);
    list_result_t predicted;
    if (!steady && $urandom_range(0, 99) < 8) begin
      op_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    op_valid <= 1'b1;
    op_kind  <= k;
    op_pos   <= pos;
    op_value <= v;
    do @(posedge clk); while (op_stall);
    predicted = apply_list_op(k, pos, v);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold off until every owed result beat has come back.
  task automatic drain_results();
    op_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result side: stall at random, except during the steady stretch.
  always @(posedge clk) begin
    res_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 8);
  end

  // Compare each accepted result beat with the oldest owed result.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t owed;
    if (!rst && res_valid && !res_stall) begin
      got = '{status_t'(res_status), res_found, res_read_value, res_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result beat with nothing owed: status %0d found %0d read %0d count %0d",
                   $realtime, got.status, got.found, got.read_value, got.count);
      end else begin
        owed = pending_results.pop_front();
        if (got !== owed) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: expected status %0d found %0d read %0d count %0d, %s",
                     $realtime, owed.status, owed.found, owed.read_value, owed.count,
                     $sformatf("got status %0d found %0d read %0d count %0d",
                               res_status, res_found, res_read_value, res_count));
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (op_valid && !op_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset, directed table, biased random stream, drain.
  initial begin
    op_mix_t                   mix;
    logic [KIND_W-1:0]         k;
    logic [POS_W-1:0]          pos;
    logic signed [DATA_W-1:0]  v;
    int                        roll;
    mix = MIX_ANY;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i])
      send_op(directed_ops[i].kind, directed_ops[i].pos, directed_ops[i].value,
              directed_ops[i].typed, directed_ops[i].want);

    // Let the engine go fully idle before the random stream starts.
    drain_results();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 60 == 0) mix = op_mix_t'($urandom_range(0, 2));
      // One long stretch with no idling on either side.
      steady <= (n >= 300 && n < 500);
      if (n == 600) drain_results();

      roll = $urandom_range(0, 99);
      if (roll < 4) k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (mix == MIX_GROW && roll < 60) k = grow_kinds[$urandom_range(0, 2)];
      else if (mix == MIX_SHRINK && roll < 55) k = shrink_kinds[$urandom_range(0, 4)];
      else k = KIND_W'($urandom_range(KIND_PUSH_BACK, KIND_BACK));

      // Mostly aim positions at live entries; sometimes anywhere.
      if ($urandom_range(0, 99) < 75)
        pos = POS_W'($urandom_range(0, (model_len > 0) ? model_len - 1 : 0));
      else pos = POS_W'($urandom_range(0, 15));

      // Reuse stored words and a small pool so searches hit and duplicates form.
      roll = $urandom_range(0, 99);
      if (roll < 35 && model_len > 0) v = model_words[$urandom_range(0, model_len - 1)];
      else if (roll < 65) v = value_pool[$urandom_range(0, 7)];
      else v = $urandom;

      send_op(k, pos, v, 1'b0, '0);
    end
    op_valid <= 1'b0;
    steady   <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
